[rtl/rcip_pkg.sv]
package rcip_pkg;

	// Result kinds carried on the output tuser field.
	typedef enum logic [1:0] {
		KIND_ROW   = 2'd0,
		KIND_ATTR  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Cell error codes.
	typedef enum logic {
		ERR_LEVEL = 1'b0,
		ERR_THIRD = 1'b1
	} err_code_t;

	localparam int unsigned CELL_PIXELS = 64;
	localparam int unsigned IDX_W       = $clog2(CELL_PIXELS);
	localparam int unsigned ROWS        = 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_PIXELS - 1);
	localparam logic [7:0] LEVEL_MID  = 8'd192;
	localparam logic [7:0] LEVEL_FULL = 8'd255;
	localparam logic [7:0] ATTR_BLANK = 8'd7;

	typedef struct packed {
		logic       valid;
		logic [3:0] colour;
	} pix_info_t;

	// Everything the output side needs to send the results of one cell.
	typedef struct packed {
		logic                  error;
		err_code_t             err_code;
		logic [IDX_W-1:0]      err_pixel;
		logic [CELL_PIXELS-1:0] bits;
		logic [7:0]            attr;
	} cell_result_t;

endpackage

[rtl/rcip_pixel_check.sv]
module rcip_pixel_check
	import rcip_pkg::*;
(
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output pix_info_t  info
);

	logic r_ok, g_ok, b_ok;
	logic has_mid, has_full;

	assign r_ok = (red == 8'd0) || (red == LEVEL_MID) || (red == LEVEL_FULL);
	assign g_ok = (green == 8'd0) || (green == LEVEL_MID) || (green == LEVEL_FULL);
	assign b_ok = (blue == 8'd0) || (blue == LEVEL_MID) || (blue == LEVEL_FULL);

	assign has_mid  = (red == LEVEL_MID) || (green == LEVEL_MID) || (blue == LEVEL_MID);
	assign has_full = (red == LEVEL_FULL) || (green == LEVEL_FULL) || (blue == LEVEL_FULL);

	assign info.valid  = r_ok && g_ok && b_ok && !(has_mid && has_full);
	assign info.colour = {((red | green | blue) == LEVEL_FULL), green[7], red[7], blue[7]};

endmodule

[rtl/rcip_cell.sv]
module rcip_cell
	import rcip_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   red,
	input  logic [7:0]   green,
	input  logic [7:0]   blue,
	output logic         done_valid,
	input  logic         done_ready,
	output cell_result_t done
);

	logic             valid_s1;
	logic [7:0]       red_s1, green_s1, blue_s1;
	logic [IDX_W-1:0] count_q;
	logic [3:0]       paper_q, ink_q;
	logic [CELL_PIXELS-1:0] bitmap_q;
	logic             err_q;
	err_code_t        err_code_q;
	logic [IDX_W-1:0] err_idx_q;

	pix_info_t        info;
	logic             take, at_end;
	logic [3:0]       paper_n, ink_n;
	logic [CELL_PIXELS-1:0] bitmap_n;
	logic             err_n;
	err_code_t        err_code_n;
	logic [IDX_W-1:0] err_idx_n;

	rcip_pixel_check u_check (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.info  (info)
	);

	assign at_end     = (count_q == LAST_IDX);
	assign done_valid = valid_s1 && at_end;
	assign take       = valid_s1 && (!at_end || done_ready);
	assign in_ready   = !valid_s1 || take;

	always_comb begin
		paper_n    = paper_q;
		ink_n      = ink_q;
		bitmap_n   = bitmap_q;
		err_n      = err_q;
		err_code_n = err_code_q;
		err_idx_n  = err_idx_q;
		if (!err_q) begin
			if (!info.valid) begin
				err_n      = 1'b1;
				err_code_n = ERR_LEVEL;
				err_idx_n  = count_q;
			end else begin
				if (count_q == '0) begin
					paper_n = info.colour;
					ink_n   = info.colour;
				end else if (info.colour != ink_q && info.colour != paper_q) begin
					if (ink_q != paper_q) begin
						err_n      = 1'b1;
						err_code_n = ERR_THIRD;
						err_idx_n  = count_q;
					end else begin
						ink_n = info.colour;
					end
				end
				if (!err_n) begin
					bitmap_n = {bitmap_q[CELL_PIXELS-2:0], (info.colour != paper_n)};
				end
			end
		end
	end

	// Attribute normalization: the lower color code becomes paper, and the bitmap is
	// inverted when the roles swap.
	always_comb begin
		done.error     = err_n;
		done.err_code  = err_code_n;
		done.err_pixel = err_idx_n;
		done.bits      = bitmap_n;
		if (paper_n == ink_n) begin
			if (ink_n != 4'd0) begin
				done.bits = '1;
				done.attr = {1'b0, ink_n[3], 3'b000, ink_n[2:0]};
			end else begin
				done.bits = '0;
				done.attr = ATTR_BLANK;
			end
		end else if (paper_n < ink_n) begin
			done.attr = {1'b0, paper_n, 3'b000} | {5'b00000, ink_n[2:0]}
				| {1'b0, ink_n[3], 6'b000000};
		end else begin
			done.bits = ~bitmap_n;
			done.attr = {1'b0, ink_n, 3'b000} | {5'b00000, paper_n[2:0]}
				| {1'b0, paper_n[3], 6'b000000};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			paper_q    <= '0;
			ink_q      <= '0;
			bitmap_q   <= '0;
			err_q      <= 1'b0;
			err_code_q <= ERR_LEVEL;
			err_idx_q  <= '0;
		end else if (take) begin
			if (at_end) begin
				count_q    <= '0;
				paper_q    <= '0;
				ink_q      <= '0;
				bitmap_q   <= '0;
				err_q      <= 1'b0;
				err_code_q <= ERR_LEVEL;
				err_idx_q  <= '0;
			end else begin
				count_q    <= count_q + 1'b1;
				paper_q    <= paper_n;
				ink_q      <= ink_n;
				bitmap_q   <= bitmap_n;
				err_q      <= err_n;
				err_code_q <= err_code_n;
				err_idx_q  <= err_idx_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && at_end |=> count_q == '0 && !err_q && bitmap_q == '0)
		else $error("cell state not cleared after the last pixel");
	a_end_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done_valid && !done_ready |=> valid_s1 && at_end)
		else $error("last pixel of a cell lost while the output side was busy");
	a_err_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(err_q) |-> $past(take))
		else $error("cell error flagged without a pixel being processed");
`endif

endmodule

[rtl/rcip_emit.sv]
module rcip_emit
	import rcip_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load_valid,
	output logic         load_ready,
	input  cell_result_t load,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   data_byte,
	output kind_t        kind,
	output err_code_t    error_code,
	output logic [IDX_W-1:0] error_pixel,
	output logic         last
);

	localparam int unsigned CNT_W = $clog2(ROWS + 1);

	logic         busy_q;
	logic [CNT_W-1:0] cnt_q;
	cell_result_t res_q;

	logic         fire, last_fire;
	logic [2:0]   row_sel;

	assign out_valid  = busy_q;
	assign fire       = busy_q && out_ready;
	assign last_fire  = fire && last;
	assign load_ready = !busy_q || last_fire;
	assign row_sel    = 3'd7 - cnt_q[2:0];

	always_comb begin
		data_byte   = 8'd0;
		kind        = KIND_ROW;
		error_code  = ERR_LEVEL;
		error_pixel = '0;
		last        = 1'b0;
		if (res_q.error) begin
			kind        = KIND_ERROR;
			error_code  = res_q.err_code;
			error_pixel = res_q.err_pixel;
			last        = 1'b1;
		end else if (cnt_q == CNT_W'(ROWS)) begin
			data_byte = res_q.attr;
			kind      = KIND_ATTR;
			last      = 1'b1;
		end else begin
			data_byte = res_q.bits[{row_sel, 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load_valid && load_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (last_fire) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			res_q <= load;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= CNT_W'(ROWS))
		else $error("row counter ran past the attribute byte");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && res_q.error |-> cnt_q == '0)
		else $error("error result advanced the row counter");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last |=> busy_q && cnt_q == $past(cnt_q) + 1'b1)
		else $error("row counter did not step after a sent row");
`endif

endmodule

[rtl/rgb_cell_to_ink_paper_attribute.sv]
// Takes the 64 RGB pixels of one 8x8 cell in row-major order, one request per
// cycle, and for each finished cell sends eight bitmap row bytes (top row first)
// followed by the attribute byte, or a single error result if a pixel had an invalid
// level or the cell held a third color. Pixels are accepted back to back at one per
// cycle: each pixel passes an input register before it is folded into the cell state.
// The results of a cell are held in an output buffer and drained at one per cycle
// while the output is ready, as the next cell streams in; the input stalls only
// when the last pixel arrives before the previous cell's results have all been taken.
module rgb_cell_to_ink_paper_attribute
	import rcip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // data_byte[7:0], error_code[8],
	                                   // error_pixel[14:9], zero[15]
	output logic [1:0]  m_axis_tuser,  // kind[1:0]
	output logic        m_axis_tlast
);

	logic             done_valid, done_ready;
	cell_result_t     done;
	logic [7:0]       data_byte;
	kind_t            kind;
	err_code_t        error_code;
	logic [IDX_W-1:0] error_pixel;

	rcip_cell u_cell (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.red        (s_axis_tdata[7:0]),
		.green      (s_axis_tdata[15:8]),
		.blue       (s_axis_tdata[23:16]),
		.done_valid (done_valid),
		.done_ready (done_ready),
		.done       (done)
	);

	rcip_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (done_valid),
		.load_ready  (done_ready),
		.load        (done),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.data_byte   (data_byte),
		.kind        (kind),
		.error_code  (error_code),
		.error_pixel (error_pixel),
		.last        (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, error_pixel, error_code, data_byte};
	assign m_axis_tuser = kind;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import rcip_pkg::*;

	typedef struct {
		logic [7:0]       data;
		kind_t            kind;
		err_code_t        code;
		logic [IDX_W-1:0] pix;
		logic             last;
	} cell_out_t;

	typedef enum {
		CELL_TWO,
		CELL_ONE,
		CELL_THIRD,
		CELL_BAD,
		CELL_NOISE
	} cell_mode_t;

	// Tracks the cell state of the encoder and holds the results that it still owes.
	class cell_encoder_model;
		logic [IDX_W-1:0] pixel_idx;
		logic [3:0]       paper;
		logic [3:0]       ink;
		logic [63:0]      bitmap;
		bit               cell_failed;
		err_code_t        err_code;
		logic [IDX_W-1:0] err_idx;
		cell_out_t        pending_results[$];
		int               failures;
		int               checked;

		function new();
			clear_cell();
			failures = 0;
			checked = 0;
		endfunction

		function void clear_cell();
			pixel_idx = '0;
			paper = '0;
			ink = '0;
			bitmap = '0;
			cell_failed = 1'b0;
			err_code = ERR_LEVEL;
			err_idx = '0;
		endfunction

		function void take_pixel(logic [23:0] px);
			logic [7:0]  r;
			logic [7:0]  g;
			logic [7:0]  b;
			logic [3:0]  c;
			bit          has_mid;
			bit          has_full;
			bit          ok;
			logic [63:0] bits;
			logic [7:0]  attr;
			r = px[7:0];
			g = px[15:8];
			b = px[23:16];
			if (!cell_failed) begin
				has_mid = (r == LEVEL_MID) || (g == LEVEL_MID) || (b == LEVEL_MID);
				has_full = (r == LEVEL_FULL) || (g == LEVEL_FULL) || (b == LEVEL_FULL);
				ok = (r == 8'd0 || r == LEVEL_MID || r == LEVEL_FULL) &&
					(g == 8'd0 || g == LEVEL_MID || g == LEVEL_FULL) &&
					(b == 8'd0 || b == LEVEL_MID || b == LEVEL_FULL) &&
					!(has_mid && has_full);
				if (!ok) begin
					cell_failed = 1'b1;
					err_code = ERR_LEVEL;
					err_idx = pixel_idx;
				end else begin
					c = {(r | g | b) == LEVEL_FULL, g[7], r[7], b[7]};
					if (pixel_idx == '0) begin
						paper = c;
						ink = c;
					end else if (c != ink && c != paper) begin
						// A new color is only allowed while ink still equals paper.
						if (ink != paper) begin
							cell_failed = 1'b1;
							err_code = ERR_THIRD;
							err_idx = pixel_idx;
						end else begin
							ink = c;
						end
					end
					if (!cell_failed)
						bitmap = {bitmap[62:0], c != paper};
				end
			end
			if (pixel_idx == LAST_IDX) begin
				if (cell_failed) begin
					pending_results.push_back('{8'd0, KIND_ERROR, err_code, err_idx, 1'b1});
				end else begin
					bits = bitmap;
					if (paper == ink) begin
						if (ink != 4'd0) begin
							bits = '1;
							attr = {1'b0, ink[3], 3'b000, ink[2:0]};
						end else begin
							bits = '0;
							attr = ATTR_BLANK;
						end
					end else if (paper < ink) begin
						attr = {1'b0, paper[3] | ink[3], paper[2:0], ink[2:0]};
					end else begin
						bits = ~bits;
						attr = {1'b0, ink[3] | paper[3], ink[2:0], paper[2:0]};
					end
					for (int l = 0; l < ROWS; l++)
						pending_results.push_back('{bits[63-8*l -: 8], KIND_ROW, ERR_LEVEL,
							'0, 1'b0});
					pending_results.push_back('{attr, KIND_ATTR, ERR_LEVEL, '0, 1'b1});
				end
				clear_cell();
			end else begin
				pixel_idx++;
			end
		endfunction

		function void check_result(logic [7:0] data, kind_t kind, err_code_t code,
			logic [IDX_W-1:0] pix, logic last);
			cell_out_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: data_byte %0d kind %0d", data, kind);
				failures++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (data !== want.data) begin
				$error("data_byte: expected %0d, actual %0d", want.data, data);
				failures++;
			end
			if (kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, kind);
				failures++;
			end
			if (code !== want.code) begin
				$error("error_code: expected %0d, actual %0d", want.code, code);
				failures++;
			end
			if (pix !== want.pix) begin
				$error("error_pixel: expected %0d, actual %0d", want.pix, pix);
				failures++;
			end
			if (last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, last);
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	cell_encoder_model model;
	logic [23:0]       cell_px[64];
	bit                steady = 1'b0;
	int                pixels_sent = 0;
	int                cells_sent = 0;

	rgb_cell_to_ink_paper_attribute dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Code 8 (bright with no color) has no valid pixel, so it is skipped.
	function automatic logic [3:0] random_colour();
		logic [3:0] c;
		c = 4'($urandom_range(0, 14));
		if (c >= 4'd8)
			c++;
		return c;
	endfunction

	function automatic logic [23:0] pixel_of(logic [3:0] c);
		logic [7:0] lv;
		lv = c[3] ? LEVEL_FULL : LEVEL_MID;
		return {c[0] ? lv : 8'd0, c[2] ? lv : 8'd0, c[1] ? lv : 8'd0};
	endfunction

	function automatic logic [7:0] level_pick();
		case ($urandom_range(0, 2))
			0: return 8'd0;
			1: return LEVEL_MID;
			default: return LEVEL_FULL;
		endcase
	endfunction

	// Fills one cell by mode: one color, two colors in random order, or two colors
	// plus a third color or invalid pixel, or noise. A cut below zero is drawn at random.
	task automatic make_cell(cell_mode_t mode, bit paper_low, int cut);
		logic [3:0]  paper;
		logic [3:0]  ink;
		logic [3:0]  third;
		logic [3:0]  tmp;
		logic [7:0]  lv[3];
		logic [7:0]  odd;
		int          rot;
		paper = random_colour();
		do ink = random_colour(); while (ink == paper);
		do third = random_colour(); while (third == paper || third == ink);
		if (paper_low != (paper < ink)) begin
			tmp = paper;
			paper = ink;
			ink = tmp;
		end
		if (cut < 0)
			cut = (mode == CELL_THIRD) ? $urandom_range(2, 63) : $urandom_range(0, 63);
		for (int i = 0; i < 64; i++) begin
			if (mode == CELL_NOISE) begin
				cell_px[i] = 24'($urandom());
			end else if (mode == CELL_ONE) begin
				cell_px[i] = pixel_of(paper);
			end else begin
				if (i == 0)
					cell_px[i] = pixel_of(paper);
				else if (i == 1 && mode == CELL_THIRD)
					cell_px[i] = pixel_of(ink);
				else
					cell_px[i] = pixel_of($urandom_range(0, 1) ? ink : paper);
				if (mode == CELL_THIRD && i == cut)
					cell_px[i] = pixel_of(third);
				if (mode == CELL_BAD && i == cut) begin
					if ($urandom_range(0, 1)) begin
						lv[0] = LEVEL_MID;
						lv[1] = LEVEL_FULL;
						lv[2] = level_pick();
					end else begin
						do odd = 8'($urandom_range(0, 255));
						while (odd == 8'd0 || odd == LEVEL_MID || odd == LEVEL_FULL);
						for (int k = 0; k < 3; k++)
							lv[k] = level_pick();
						lv[$urandom_range(0, 2)] = odd;
					end
					rot = $urandom_range(0, 2);
					cell_px[i] = {lv[(rot + 2) % 3], lv[(rot + 1) % 3], lv[rot]};
				end
				// Pixels after an error only advance the count.
				if (mode != CELL_TWO && i > cut && $urandom_range(0, 3) == 0)
					cell_px[i] = 24'($urandom());
			end
		end
	endtask

	task automatic send_pixel(logic [23:0] px);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		model.take_pixel(px);
		pixels_sent++;
	endtask

	task automatic push_cell();
		steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < 64; i++)
			send_pixel(cell_px[i]);
		cells_sent++;
	endtask

	initial begin
		logic [7:0] edges[8];
		model = new();
		edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd191, 8'd193, 8'd254, 8'd255};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Blank cell, then a uniform bright white cell.
		for (int i = 0; i < 64; i++)
			cell_px[i] = 24'h000000;
		push_cell();
		for (int i = 0; i < 64; i++)
			cell_px[i] = 24'hFFFFFF;
		push_cell();
		// Mixed 192 and 255 on the first pixel, then boundary byte values.
		cell_px[0] = {8'd0, LEVEL_FULL, LEVEL_MID};
		for (int i = 1; i < 64; i++)
			cell_px[i] = {edges[(i + 3) % 8], edges[(i / 8) % 8], edges[i % 8]};
		push_cell();
		// Third color on the very last pixel of the cell.
		make_cell(CELL_THIRD, 1'b1, 63);
		push_cell();

		make_cell(CELL_TWO, 1'b1, -1);
		push_cell();
		make_cell(CELL_TWO, 1'b0, -1);
		push_cell();
		s_axis_tvalid <= 1'b0;

		while (model.pending_results.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		$display("Sent %0d pixels in %0d cells; %0d results compared.",
			pixels_sent, cells_sent, model.checked);
		if (model.failures == 0 && model.pending_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Result side: random stalls, each accepted request checked against the model.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			model.check_result(m_axis_tdata[7:0], kind_t'(m_axis_tuser),
				err_code_t'(m_axis_tdata[8]), m_axis_tdata[14:9], m_axis_tlast);
		end
	end

	initial begin
		#400000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
